>>> hw/rtl/pnm_header_parse_bgr_unpack_unit_assert.svh
// assertion macros used by the checker file of the pnm decoder
`ifndef PNM_HEADER_PARSE_BGR_UNPACK_UNIT_ASSERT_SVH
`define PNM_HEADER_PARSE_BGR_UNPACK_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define PNM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pnm check failed");

// next-cycle implication, sampled on clock, off during reset
`define PNM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pnm check failed");

`endif

>>> hw/rtl/pnm_pkg.sv
// package: types, codes and constants of the pnm decoder
`timescale 1ns / 1ps
`default_nettype none

package pnm_pkg;

   localparam logic [16:0] MAX_DIM     = 17'd16384;
   localparam logic [16:0] TOKEN_LIMIT = 17'd100000;
   localparam logic [16:0] MAXVAL_REQ  = 17'd255;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_5     = 8'h35;
   localparam logic [7:0] CHAR_6     = 8'h36;
   localparam logic [7:0] CHAR_HASH  = 8'h23;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0a;
   localparam logic [7:0] CHAR_CR    = 8'h0d;

   typedef enum logic [2:0] {
      KIND_PIXEL = 3'd0,
      KIND_DONE  = 3'd1,
      KIND_MAGIC = 3'd2,
      KIND_TOKEN = 3'd3,
      KIND_DIMS  = 3'd4,
      KIND_TRUNC = 3'd5
   } pnm_kind_type;

   typedef enum logic [3:0] {
      PH_MAGIC_P = 4'd0,
      PH_MAGIC_D = 4'd1,
      PH_SKIP_W  = 4'd2,
      PH_DIG_W   = 4'd3,
      PH_SKIP_H  = 4'd4,
      PH_DIG_H   = 4'd5,
      PH_SKIP_M  = 4'd6,
      PH_DIG_M   = 4'd7,
      PH_PAYLOAD = 4'd8,
      PH_IDLE    = 4'd9
   } pnm_phase_type;

   // one or two results produced by one input byte
   typedef struct packed {
      logic         two;
      pnm_kind_type kind_a;
      pnm_kind_type kind_b;
      logic [7:0]   blue;
      logic [7:0]   green;
      logic [7:0]   red;
      logic [14:0]  width;
      logic [14:0]  height;
   } pnm_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } pnm_qstat_type;

endpackage

`default_nettype wire

>>> hw/rtl/pnm_queue.sv
// small register queue between the byte parser and the result sender
`timescale 1ns / 1ps
`default_nettype none

module pnm_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire pnm_pkg::pnm_entry_type push_entry,
   input  wire logic                  pop,
   output pnm_pkg::pnm_entry_type      head_entry,
   output pnm_pkg::pnm_qstat_type      qstat
);

   pnm_pkg::pnm_entry_type           slot_ff [pnm_pkg::QUEUE_DEPTH];
   logic [pnm_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [pnm_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [pnm_pkg::QCNT_W-1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? pnm_pkg::QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? pnm_pkg::QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = pnm_pkg::QCNT_W'(count_ff + {{(pnm_pkg::QCNT_W-1){1'b0}}, push}
                  - {{(pnm_pkg::QCNT_W-1){1'b0}}, pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry  = slot_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == pnm_pkg::QCNT_W'(pnm_pkg::QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

endmodule

`default_nettype wire

>>> hw/rtl/pnm_front.sv
// byte parser: header state machine, payload unpacking, result classification
`timescale 1ns / 1ps
`default_nettype none

module pnm_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire logic [7:0]             data_byte,
   input  wire logic                   end_of_file,
   output logic                        push,
   output pnm_pkg::pnm_entry_type       push_entry
);

   pnm_pkg::pnm_phase_type phase_ff, phase_in, phase_step;
   logic        gray_ff, gray_in;
   logic        comment_ff, comment_in;
   logic [16:0] token_ff, token_in;
   logic [16:0] width_ff, width_in;
   logic [16:0] height_ff, height_in;
   logic [28:0] pixels_ff, pixels_in;
   logic [1:0]  chan_ff, chan_in;
   logic [7:0]  held_red_ff, held_red_in;
   logic [7:0]  held_green_ff, held_green_in;

   logic        is_digit, is_space, is_hash, is_lf;
   logic [3:0]  digit_val;
   logic [20:0] tok_mul;
   logic        tok_over;
   logic [16:0] token_next;
   logic        hdr_ok;
   logic        skip_cmt, skip_bad;
   logic [29:0] pixel_prod;
   logic        pix_emit;
   logic [28:0] pixels_dec;
   logic        in_digits;

   logic                 main_valid, done_flag, eof_valid;
   pnm_pkg::pnm_kind_type main_kind, eof_kind;
   logic [7:0]           pix_green, pix_red;

   // byte classes
   always_comb begin
      is_digit  = data_byte inside {[pnm_pkg::CHAR_0:pnm_pkg::CHAR_9]};
      is_space  = data_byte inside {pnm_pkg::CHAR_SPACE, pnm_pkg::CHAR_TAB,
                                    pnm_pkg::CHAR_LF, pnm_pkg::CHAR_CR};
      is_hash   = (data_byte == pnm_pkg::CHAR_HASH);
      is_lf     = (data_byte == pnm_pkg::CHAR_LF);
      digit_val = 4'(data_byte - pnm_pkg::CHAR_0);
   end

   // running decimal value: v*10 + d as shifts and adds
   assign tok_mul  = {token_ff, 3'b000} + {3'b000, token_ff, 1'b0} + {17'd0, digit_val};
   assign tok_over = (tok_mul > {4'd0, pnm_pkg::TOKEN_LIMIT});

   assign in_digits  = (phase_ff == pnm_pkg::PH_DIG_W) || (phase_ff == pnm_pkg::PH_DIG_H)
                       || (phase_ff == pnm_pkg::PH_DIG_M);
   // token value after this byte: a digit outside a token starts a new one
   assign token_next = !is_digit ? token_ff
                       : (in_digits ? tok_mul[16:0] : {13'd0, digit_val});

   assign hdr_ok = (width_ff != '0) && (width_ff <= pnm_pkg::MAX_DIM)
                   && (height_ff != '0) && (height_ff <= pnm_pkg::MAX_DIM)
                   && (token_next == pnm_pkg::MAXVAL_REQ);

   // a token that ends on this byte starts the skip with no comment open
   assign skip_cmt = in_digits ? 1'b0 : comment_ff;
   assign skip_bad = !skip_cmt && !is_hash && !is_space && !is_digit;

   assign pixel_prod = 30'(width_ff[14:0]) * 30'(height_ff[14:0]);

   assign pix_emit   = (phase_ff == pnm_pkg::PH_PAYLOAD) && (gray_ff || (chan_ff == 2'd2));
   assign pixels_dec = pixels_ff - {28'd0, pix_emit};

   // next state
   always_comb begin
      logic                   skip_act;
      pnm_pkg::pnm_phase_type skip_target;

      skip_act      = 1'b0;
      skip_target   = pnm_pkg::PH_DIG_W;
      phase_step    = phase_ff;
      gray_in       = gray_ff;
      comment_in    = comment_ff;
      token_in      = token_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      pixels_in     = pixels_ff;
      chan_in       = chan_ff;
      held_red_in   = held_red_ff;
      held_green_in = held_green_ff;

      case (phase_ff)
         pnm_pkg::PH_MAGIC_P: begin
            phase_step = (data_byte == pnm_pkg::CHAR_P) ? pnm_pkg::PH_MAGIC_D
                                                        : pnm_pkg::PH_IDLE;
         end
         pnm_pkg::PH_MAGIC_D: begin
            if (data_byte == pnm_pkg::CHAR_5 || data_byte == pnm_pkg::CHAR_6) begin
               gray_in    = (data_byte == pnm_pkg::CHAR_5);
               comment_in = 1'b0;
               phase_step = pnm_pkg::PH_SKIP_W;
            end else begin
               phase_step = pnm_pkg::PH_IDLE;
            end
         end
         pnm_pkg::PH_SKIP_W: begin
            skip_act    = 1'b1;
            skip_target = pnm_pkg::PH_DIG_W;
         end
         pnm_pkg::PH_SKIP_H: begin
            skip_act    = 1'b1;
            skip_target = pnm_pkg::PH_DIG_H;
         end
         pnm_pkg::PH_SKIP_M: begin
            skip_act    = 1'b1;
            skip_target = pnm_pkg::PH_DIG_M;
         end
         pnm_pkg::PH_DIG_W, pnm_pkg::PH_DIG_H, pnm_pkg::PH_DIG_M: begin
            if (is_digit) begin
               token_in = tok_mul[16:0];
               if (tok_over) begin
                  phase_step = pnm_pkg::PH_IDLE;
               end
            end else if (phase_ff == pnm_pkg::PH_DIG_W) begin
               width_in    = token_ff;
               phase_step  = pnm_pkg::PH_SKIP_H;
               skip_act    = 1'b1;
               skip_target = pnm_pkg::PH_DIG_H;
            end else if (phase_ff == pnm_pkg::PH_DIG_H) begin
               height_in   = token_ff;
               phase_step  = pnm_pkg::PH_SKIP_M;
               skip_act    = 1'b1;
               skip_target = pnm_pkg::PH_DIG_M;
            end else if (!hdr_ok) begin
               phase_step = pnm_pkg::PH_IDLE;
            end else begin
               // this byte is the single separator before the payload
               pixels_in  = pixel_prod[28:0];
               chan_in    = 2'd0;
               phase_step = pnm_pkg::PH_PAYLOAD;
            end
         end
         pnm_pkg::PH_PAYLOAD: begin
            if (!gray_ff) begin
               case (chan_ff)
                  2'd0: begin
                     held_red_in = data_byte;
                     chan_in     = 2'd1;
                  end
                  2'd1: begin
                     held_green_in = data_byte;
                     chan_in       = 2'd2;
                  end
                  default: begin
                     chan_in = 2'd0;
                  end
               endcase
            end
            pixels_in = pixels_dec;
            if (pixels_dec == '0) begin
               phase_step = pnm_pkg::PH_IDLE;
            end
         end
         default: begin
         end
      endcase

      if (skip_act) begin
         comment_in = skip_cmt;
         if (skip_cmt) begin
            if (is_lf) begin
               comment_in = 1'b0;
            end
         end else if (is_hash) begin
            comment_in = 1'b1;
         end else if (is_space) begin
            comment_in = 1'b0;
         end else if (is_digit) begin
            token_in   = {13'd0, digit_val};
            phase_step = skip_target;
         end else begin
            phase_step = pnm_pkg::PH_IDLE;
         end
      end

      phase_in = end_of_file ? pnm_pkg::PH_MAGIC_P : phase_step;
   end

   // results of this byte
   always_comb begin
      main_valid = 1'b0;
      main_kind  = pnm_pkg::KIND_PIXEL;
      done_flag  = 1'b0;
      pix_green  = gray_ff ? data_byte : held_green_ff;
      pix_red    = gray_ff ? data_byte : held_red_ff;

      case (phase_ff)
         pnm_pkg::PH_MAGIC_P: begin
            if (data_byte != pnm_pkg::CHAR_P) begin
               main_valid = 1'b1;
               main_kind  = pnm_pkg::KIND_MAGIC;
            end
         end
         pnm_pkg::PH_MAGIC_D: begin
            if (data_byte != pnm_pkg::CHAR_5 && data_byte != pnm_pkg::CHAR_6) begin
               main_valid = 1'b1;
               main_kind  = pnm_pkg::KIND_MAGIC;
            end
         end
         pnm_pkg::PH_SKIP_W, pnm_pkg::PH_SKIP_H, pnm_pkg::PH_SKIP_M: begin
            if (skip_bad) begin
               main_valid = 1'b1;
               main_kind  = pnm_pkg::KIND_TOKEN;
            end
         end
         pnm_pkg::PH_DIG_W, pnm_pkg::PH_DIG_H, pnm_pkg::PH_DIG_M: begin
            if (is_digit) begin
               if (tok_over) begin
                  main_valid = 1'b1;
                  main_kind  = pnm_pkg::KIND_TOKEN;
               end
            end else if (phase_ff != pnm_pkg::PH_DIG_M) begin
               if (skip_bad) begin
                  main_valid = 1'b1;
                  main_kind  = pnm_pkg::KIND_TOKEN;
               end
            end else if (!hdr_ok) begin
               main_valid = 1'b1;
               main_kind  = pnm_pkg::KIND_DIMS;
            end
         end
         pnm_pkg::PH_PAYLOAD: begin
            main_valid = pix_emit;
            main_kind  = pnm_pkg::KIND_PIXEL;
            done_flag  = (pixels_dec == '0);
         end
         default: begin
         end
      endcase

      eof_valid = 1'b0;
      eof_kind  = pnm_pkg::KIND_TRUNC;
      if (end_of_file) begin
         case (phase_step)
            pnm_pkg::PH_MAGIC_P, pnm_pkg::PH_MAGIC_D: begin
               eof_valid = 1'b1;
               eof_kind  = pnm_pkg::KIND_MAGIC;
            end
            pnm_pkg::PH_SKIP_W, pnm_pkg::PH_DIG_W, pnm_pkg::PH_SKIP_H,
            pnm_pkg::PH_DIG_H, pnm_pkg::PH_SKIP_M: begin
               eof_valid = 1'b1;
               eof_kind  = pnm_pkg::KIND_TOKEN;
            end
            pnm_pkg::PH_DIG_M: begin
               eof_valid = 1'b1;
               eof_kind  = hdr_ok ? pnm_pkg::KIND_TRUNC : pnm_pkg::KIND_DIMS;
            end
            pnm_pkg::PH_PAYLOAD: begin
               eof_valid = 1'b1;
               eof_kind  = pnm_pkg::KIND_TRUNC;
            end
            default: begin
            end
         endcase
      end

      push = accept && (main_valid || done_flag || eof_valid);

      push_entry.kind_a = main_valid ? main_kind
                        : (done_flag ? pnm_pkg::KIND_DONE : eof_kind);
      push_entry.two    = (main_valid && done_flag) || (main_valid && eof_valid)
                          || (done_flag && eof_valid);
      push_entry.kind_b = (main_valid && done_flag) ? pnm_pkg::KIND_DONE : eof_kind;
      push_entry.blue   = data_byte;
      push_entry.green  = pix_green;
      push_entry.red    = pix_red;
      push_entry.width  = width_ff[14:0];
      push_entry.height = height_ff[14:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= pnm_pkg::PH_MAGIC_P;
         comment_ff <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         comment_ff <= end_of_file ? 1'b0 : comment_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         gray_ff       <= gray_in;
         token_ff      <= token_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         pixels_ff     <= pixels_in;
         chan_ff       <= chan_in;
         held_red_ff   <= held_red_in;
         held_green_ff <= held_green_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/pnm_back.sv
// result sender: splits queue entries into single results behind an output register
`timescale 1ns / 1ps
`default_nettype none

module pnm_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire pnm_pkg::pnm_entry_type  head_entry,
   input  wire pnm_pkg::pnm_qstat_type  qstat,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [2:0]                  rsp_kind,
   output logic [7:0]                  rsp_blue,
   output logic [7:0]                  rsp_green,
   output logic [7:0]                  rsp_red,
   output logic [14:0]                 rsp_image_width,
   output logic [14:0]                 rsp_image_height,
   output logic                        rsp_is_last
);

   logic                  valid_ff, valid_in;
   logic                  sel_ff, sel_in;
   logic                  load;
   pnm_pkg::pnm_kind_type kind_sel;

   pnm_pkg::pnm_kind_type kind_ff, kind_in;
   logic [7:0]            blue_ff, blue_in;
   logic [7:0]            green_ff, green_in;
   logic [7:0]            red_ff, red_in;
   logic [14:0]           width_ff, width_in;
   logic [14:0]           height_ff, height_in;
   logic                  last_ff, last_in;

   always_comb begin
      load     = !valid_ff || !rsp_stall;
      kind_sel = sel_ff ? head_entry.kind_b : head_entry.kind_a;
      // the second result of an entry is always the closing one
      pop      = load && !qstat.empty && (sel_ff || !head_entry.two);
      valid_in = load ? !qstat.empty : valid_ff;
      sel_in   = (load && !qstat.empty) ? (head_entry.two && !sel_ff) : sel_ff;

      kind_in   = kind_sel;
      blue_in   = (kind_sel == pnm_pkg::KIND_PIXEL) ? head_entry.blue : 8'd0;
      green_in  = (kind_sel == pnm_pkg::KIND_PIXEL) ? head_entry.green : 8'd0;
      red_in    = (kind_sel == pnm_pkg::KIND_PIXEL) ? head_entry.red : 8'd0;
      width_in  = (kind_sel == pnm_pkg::KIND_DONE) ? head_entry.width : 15'd0;
      height_in = (kind_sel == pnm_pkg::KIND_DONE) ? head_entry.height : 15'd0;
      last_in   = sel_ff || !head_entry.two;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && !qstat.empty) begin
         kind_ff   <= kind_in;
         blue_ff   <= blue_in;
         green_ff  <= green_in;
         red_ff    <= red_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_blue         = blue_ff;
   assign rsp_green        = green_ff;
   assign rsp_red          = red_ff;
   assign rsp_image_width  = width_ff;
   assign rsp_image_height = height_ff;
   assign rsp_is_last      = last_ff;

endmodule

`default_nettype wire

>>> hw/rtl/pnm_header_parse_bgr_unpack_unit.sv
// Binary PNM (P5/P6) decoder top level. One file byte is taken per cycle with no gaps of
// its own: the parser classifies each byte combinationally as it is taken and writes the
// one or two results it causes into a four-entry queue. The sender drains that queue at
// one result per cycle while rsp_stall is low, through an output register, so a result
// passes through the queue and then the output register before it is offered. Bytes that
// give two results (last pixel plus completion, or a result plus the end-of-file status)
// are sent as two results, one after the other; req_stall rises only when the queue is
// full, i.e. when the result side has been stalled or has fallen behind by four entries.
// Pixels come out blue, green, red; gray bytes fill all three channels.
`timescale 1ns / 1ps
`default_nettype none

module pnm_header_parse_bgr_unpack_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_file,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [7:0]       rsp_blue,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_red,
   output logic [14:0]      rsp_image_width,
   output logic [14:0]      rsp_image_height,
   output logic             rsp_is_last
);

   logic                   req_transfer;
   logic                   push;
   logic                   pop;
   pnm_pkg::pnm_entry_type push_entry;
   pnm_pkg::pnm_entry_type head_entry;
   pnm_pkg::pnm_qstat_type qstat;

   assign req_stall    = qstat.full;
   assign req_transfer = req_valid && !req_stall;

   pnm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_transfer),
      .data_byte   (req_data_byte),
      .end_of_file (req_end_of_file),
      .push        (push),
      .push_entry  (push_entry)
   );

   pnm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .qstat      (qstat)
   );

   pnm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_entry       (head_entry),
      .qstat            (qstat),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_blue         (rsp_blue),
      .rsp_green        (rsp_green),
      .rsp_red          (rsp_red),
      .rsp_image_width  (rsp_image_width),
      .rsp_image_height (rsp_image_height),
      .rsp_is_last      (rsp_is_last)
   );

endmodule

`default_nettype wire

>>> hw/rtl/pnm_checker.sv
// port-level checks of the pnm decoder, bound to its top level
`timescale 1ns / 1ps
`default_nettype none
`include "pnm_header_parse_bgr_unpack_unit_assert.svh"

module pnm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [2:0]  rsp_kind,
   input wire logic [7:0]  rsp_blue,
   input wire logic [7:0]  rsp_green,
   input wire logic [7:0]  rsp_red,
   input wire logic [14:0] rsp_image_width,
   input wire logic [14:0] rsp_image_height,
   input wire logic        rsp_is_last
);

   logic [57:0] rsp_payload;
   logic        is_pixel;
   logic        is_done;
   logic        no_size;
   logic        no_color;

   assign rsp_payload = {rsp_kind, rsp_blue, rsp_green, rsp_red, rsp_image_width,
                         rsp_image_height, rsp_is_last};
   assign is_pixel    = rsp_valid && (rsp_kind == pnm_pkg::KIND_PIXEL);
   assign is_done     = rsp_valid && (rsp_kind == pnm_pkg::KIND_DONE);
   assign no_size     = (rsp_image_width == 15'd0) && (rsp_image_height == 15'd0);
   assign no_color    = (rsp_blue == 8'd0) && (rsp_green == 8'd0) && (rsp_red == 8'd0);

   // a stalled result keeps its payload
   `PNM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // pixels carry no size
   `PNM_ASSERT_NOW(a_pixel_no_size, is_pixel, no_size)

   // status results close the byte and carry no color
   `PNM_ASSERT_NOW(a_status_last, rsp_valid && !is_pixel, rsp_is_last && no_color)

   // completion reports a checked, nonzero size
   `PNM_ASSERT_NOW(a_done_size, is_done, rsp_image_width != '0 && rsp_image_height != '0)

   // with nothing offered the queue cannot be full
   `PNM_ASSERT_NOW(a_idle_open, !rsp_valid, !req_stall)

endmodule

bind pnm_header_parse_bgr_unpack_unit pnm_checker u_checker (.*);

`default_nettype wire

>>> sim/tb_top.sv
// self-checking testbench of the pnm decoder: byte files in, bgr pixels and status checked
`timescale 1ns / 1ps

import pnm_pkg::*;

typedef struct {
   pnm_kind_type kind;
   logic [7:0]   blue;
   logic [7:0]   green;
   logic [7:0]   red;
   logic [14:0]  width;
   logic [14:0]  height;
   logic         is_last;
} bgr_result_type;

// tracks the decoder state byte by byte and holds the results it still owes
class pnm_decode_tracker;
   pnm_phase_type  phase;
   bit             gray_mode;
   bit             in_comment;
   bit             error_latched;
   int unsigned    token_value;
   int unsigned    width_tok;
   int unsigned    height_tok;
   int unsigned    pixels_left;
   bit [1:0]       chan_index;
   logic [7:0]     held_red;
   logic [7:0]     held_green;
   bgr_result_type fresh[$];
   bgr_result_type awaited[$];
   int unsigned    mismatches;
   int unsigned    kind_count[6];

   function new();
      clear_state();
      mismatches = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
   endfunction

   function void clear_state();
      phase = PH_MAGIC_P;
      gray_mode = 0;
      in_comment = 0;
      error_latched = 0;
      token_value = 0;
      width_tok = 0;
      height_tok = 0;
      pixels_left = 0;
      chan_index = 0;
      held_red = 0;
      held_green = 0;
   endfunction

   function int unsigned outstanding();
      return awaited.size();
   endfunction

   function bit is_digit(logic [7:0] c);
      return c >= CHAR_0 && c <= CHAR_9;
   endfunction

   function bit is_skip(logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_CR;
   endfunction

   function void emit(pnm_kind_type kind, logic [7:0] b, logic [7:0] g, logic [7:0] r,
                      logic [14:0] w, logic [14:0] h);
      bgr_result_type res;
      res.kind = kind;
      res.blue = b;
      res.green = g;
      res.red = r;
      res.width = w;
      res.height = h;
      res.is_last = 0;
      fresh.push_back(res);
   endfunction

   function void fail_with(pnm_kind_type kind);
      emit(kind, 0, 0, 0, 0, 0);
      phase = PH_IDLE;
      error_latched = 1;
   endfunction

   // byte between tokens: whitespace, comment text or the first digit of a token
   function bit gap_byte(logic [7:0] c, pnm_phase_type digit_phase);
      if (in_comment) begin
         if (c == CHAR_LF) in_comment = 0;
         return 1;
      end
      if (c == CHAR_HASH) begin
         in_comment = 1;
         return 1;
      end
      if (is_skip(c)) return 1;
      if (is_digit(c)) begin
         token_value = c - CHAR_0;
         phase = digit_phase;
         return 1;
      end
      return 0;
   endfunction

   function bit header_ok();
      return width_tok >= 1 && width_tok <= MAX_DIM && height_tok >= 1 &&
             height_tok <= MAX_DIM && token_value == MAXVAL_REQ;
   endfunction

   function void take_file_byte(logic [7:0] c, logic eof);
      fresh.delete();
      case (phase)
         PH_MAGIC_P: begin
            if (c == CHAR_P) phase = PH_MAGIC_D;
            else fail_with(KIND_MAGIC);
         end
         PH_MAGIC_D: begin
            if (c == CHAR_5 || c == CHAR_6) begin
               gray_mode = (c == CHAR_5);
               in_comment = 0;
               phase = PH_SKIP_W;
            end else begin
               fail_with(KIND_MAGIC);
            end
         end
         PH_SKIP_W, PH_SKIP_H, PH_SKIP_M: begin
            if (!gap_byte(c, pnm_phase_type'(phase + 1))) fail_with(KIND_TOKEN);
         end
         PH_DIG_W, PH_DIG_H, PH_DIG_M: begin
            if (is_digit(c)) begin
               token_value = token_value * 10 + (c - CHAR_0);
               if (token_value > TOKEN_LIMIT) fail_with(KIND_TOKEN);
            end else if (phase != PH_DIG_M) begin
               if (phase == PH_DIG_W) width_tok = token_value;
               else height_tok = token_value;
               phase = pnm_phase_type'(phase + 1);
               in_comment = 0;
               if (!gap_byte(c, pnm_phase_type'(phase + 1))) fail_with(KIND_TOKEN);
            end else if (!header_ok()) begin
               fail_with(KIND_DIMS);
            end else begin
               // the byte ending maxval is the one separator before the payload
               pixels_left = width_tok * height_tok;
               chan_index = 0;
               phase = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (gray_mode) begin
               emit(KIND_PIXEL, c, c, c, 0, 0);
               pixels_left--;
            end else if (chan_index == 0) begin
               held_red = c;
               chan_index = 1;
            end else if (chan_index == 1) begin
               held_green = c;
               chan_index = 2;
            end else begin
               emit(KIND_PIXEL, c, held_green, held_red, 0, 0);
               chan_index = 0;
               pixels_left--;
            end
            if (pixels_left == 0) begin
               emit(KIND_DONE, 0, 0, 0, 15'(width_tok), 15'(height_tok));
               phase = PH_IDLE;
            end
         end
         default: ;
      endcase
      if (eof) begin
         case (phase)
            PH_MAGIC_P, PH_MAGIC_D: emit(KIND_MAGIC, 0, 0, 0, 0, 0);
            PH_SKIP_W, PH_DIG_W, PH_SKIP_H, PH_DIG_H, PH_SKIP_M:
               emit(KIND_TOKEN, 0, 0, 0, 0, 0);
            PH_DIG_M: emit(header_ok() ? KIND_TRUNC : KIND_DIMS, 0, 0, 0, 0, 0);
            PH_PAYLOAD: emit(KIND_TRUNC, 0, 0, 0, 0, 0);
            default: ;
         endcase
         clear_state();
      end
      if (fresh.size() > 0) fresh[fresh.size() - 1].is_last = 1;
      foreach (fresh[i]) awaited.push_back(fresh[i]);
   endfunction

   function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   function void match_result(bgr_result_type got);
      bgr_result_type want;
      if (awaited.size() == 0) begin
         $display("%0t: unexpected result, kind %0d", $time, got.kind);
         mismatches++;
         return;
      end
      want = awaited.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("blue", want.blue, got.blue);
      compare_field("green", want.green, got.green);
      compare_field("red", want.red, got.red);
      compare_field("image_width", want.width, got.width);
      compare_field("image_height", want.height, got.height);
      compare_field("is_last", want.is_last, got.is_last);
      kind_count[want.kind]++;
   endfunction
endclass

module tb_top;
   localparam int STALL_PCT   = 14;
   localparam int HOLD_CYCLES = 60;
   localparam int IDLE_LIMIT  = 2000;
   localparam int BYTE_TARGET = 1050;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_file = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_red;
   logic [14:0] rsp_image_width;
   logic [14:0] rsp_image_height;
   logic        rsp_is_last;

   logic [7:0]  file_bytes[$];
   pnm_decode_tracker decode = new();
   bit          calm = 0;
   bit          hold_request = 0;
   int          hold_left = 0;
   int          idle_cycles = 0;
   int          files_sent = 0;
   int          bytes_sent = 0;

   pnm_header_parse_bgr_unpack_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_end_of_file  (req_end_of_file),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_blue         (rsp_blue),
      .rsp_green        (rsp_green),
      .rsp_red          (rsp_red),
      .rsp_image_width  (rsp_image_width),
      .rsp_image_height (rsp_image_height),
      .rsp_is_last      (rsp_is_last)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side: random stalls, a calm stretch, and one long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < STALL_PCT);
      end
   end

   always @(posedge clock) begin
      bgr_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind = pnm_kind_type'(rsp_kind);
         got.blue = rsp_blue;
         got.green = rsp_green;
         got.red = rsp_red;
         got.width = rsp_image_width;
         got.height = rsp_image_height;
         got.is_last = rsp_is_last;
         decode.match_result(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("pnm_header_parse_bgr_unpack_unit: mismatch");
      $finish;
   end

   function automatic void add_char(logic [7:0] c);
      file_bytes.push_back(c);
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
   endfunction

   function automatic void add_random(int n);
      for (int i = 0; i < n; i++) add_char(8'($urandom_range(255, 0)));
   endfunction

   function automatic void add_number(int unsigned v);
      string digits;
      if ($urandom_range(3, 0) == 0) repeat ($urandom_range(2, 1)) add_char(CHAR_0);
      digits = $sformatf("%0d", v);
      add_text(digits);
   endfunction

   // whitespace and comments between header tokens
   function automatic void add_gap(bit may_be_empty);
      int pieces;
      int n;
      logic [7:0] c;
      pieces = $urandom_range(3, may_be_empty ? 0 : 1);
      for (int i = 0; i < pieces; i++) begin
         case ($urandom_range(5, 0))
            0: add_char(CHAR_SPACE);
            1: add_char(CHAR_TAB);
            2: add_char(CHAR_LF);
            3: add_char(CHAR_CR);
            default: begin
               add_char(CHAR_HASH);
               n = $urandom_range(5, 0);
               for (int j = 0; j < n; j++) begin
                  c = 8'($urandom_range(255, 0));
                  if (c == CHAR_LF) c = CHAR_SPACE;
                  add_char(c);
               end
               add_char(CHAR_LF);
            end
         endcase
      end
   endfunction

   function automatic void add_header(bit gray, int unsigned w, int unsigned h,
                                      int unsigned m);
      logic [7:0] sep;
      add_char(CHAR_P);
      add_char(gray ? CHAR_5 : CHAR_6);
      add_gap(1);
      add_number(w);
      add_gap(0);
      add_number(h);
      add_gap(0);
      add_number(m);
      case ($urandom_range(7, 0))
         0: sep = CHAR_SPACE;
         1: sep = CHAR_TAB;
         2: sep = CHAR_CR;
         3, 4: sep = CHAR_LF;
         default: begin
            // any non-digit ends maxval and serves as the separator
            sep = 8'($urandom_range(255, 0));
            if (sep >= CHAR_0 && sep <= CHAR_9) sep = CHAR_HASH;
         end
      endcase
      add_char(sep);
   endfunction

   function automatic void build_random_file();
      bit          gray;
      int unsigned w;
      int unsigned h;
      int unsigned m;
      int unsigned full;
      int unsigned pick;
      int unsigned pos;
      logic [7:0]  bad;
      gray = $urandom_range(1, 0);
      w = $urandom_range(4, 1);
      h = $urandom_range(4, 1);
      m = MAXVAL_REQ;
      pick = $urandom_range(99, 0);
      if (pick < 65) begin
         if ($urandom_range(9, 0) == 0) begin
            // largest sizes, cut short early in the payload
            case ($urandom_range(2, 0))
               0: w = MAX_DIM;
               1: h = MAX_DIM;
               default: begin
                  w = MAX_DIM;
                  h = MAX_DIM;
               end
            endcase
            add_header(gray, w, h, m);
            add_random($urandom_range(5, 0));
         end else begin
            add_header(gray, w, h, m);
            full = w * h * (gray ? 1 : 3);
            case ($urandom_range(9, 0))
               0, 1: add_random($urandom_range(full - 1, 0));
               2, 3: add_random(full + $urandom_range(4, 1));
               default: add_random(full);
            endcase
         end
      end else if (pick < 90) begin
         case ($urandom_range(3, 0))
            0: begin
               case ($urandom_range(4, 0))
                  0: w = 0;
                  1: w = MAX_DIM + 1;
                  2: h = 0;
                  3: h = MAX_DIM + 1;
                  default: begin
                     m = $urandom_range(1, 0) ? $urandom_range(100000, 0) : 254;
                     if (m == MAXVAL_REQ) m = 256;
                  end
               endcase
               add_header(gray, w, h, m);
               add_random($urandom_range(3, 0));
            end
            1: begin
               // tokens at and past the limit
               case ($urandom_range(2, 0))
                  0: w = $urandom_range(999999, 100000);
                  1: h = $urandom_range(999999, 100000);
                  default: m = $urandom_range(9999999, 100000);
               endcase
               add_header(gray, w, h, m);
               add_random($urandom_range(2, 0));
            end
            2: begin
               // file ends somewhere inside the header
               add_header(gray, w, h, m);
               pos = $urandom_range(file_bytes.size() - 1, 1);
               while (file_bytes.size() > pos) void'(file_bytes.pop_back());
            end
            default: begin
               add_header(gray, w, h, m);
               pos = $urandom_range(file_bytes.size() - 1, 0);
               bad = 8'($urandom_range(255, 0));
               if (bad <= CHAR_SPACE || (bad >= CHAR_0 && bad <= CHAR_9) || bad == CHAR_HASH)
                  bad = 8'hc0 | bad[5:0];
               file_bytes[pos] = bad;
               add_random($urandom_range(3, 0));
            end
         endcase
      end else begin
         add_random($urandom_range(8, 1));
         if ($urandom_range(1, 0)) file_bytes[0] = CHAR_P;
      end
   endfunction

   task automatic drive_byte(logic [7:0] d, logic eof);
      if (!calm && $urandom_range(99, 0) < STALL_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_end_of_file <= eof;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode.take_file_byte(d, eof);
      @(negedge clock);
   endtask

   task automatic send_file();
      for (int i = 0; i < file_bytes.size(); i++)
         drive_byte(file_bytes[i], i == file_bytes.size() - 1);
      files_sent++;
      bytes_sent += file_bytes.size();
      file_bytes.delete();
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (decode.outstanding() != 0);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // last pixel on the last byte, darkest gray
      add_text("P5 1 1 255\n");
      add_char(8'h00);
      send_file();
      // token right after the magic, brightest rgb
      add_text("P61 1 255 ");
      add_random(0);
      add_char(8'hff);
      add_char(8'hff);
      add_char(8'hff);
      send_file();
      add_text("Q");
      send_file();
      wait_drained();

      while (bytes_sent < BYTE_TARGET) begin
         calm = (files_sent >= 14 && files_sent < 26);
         if (files_sent == 34) wait_drained();
         if (files_sent == 8) begin
            // result side holds off while a full gray image streams in
            hold_request = 1;
            add_header(1, 4, 4, MAXVAL_REQ);
            add_random(16);
         end else begin
            build_random_file();
         end
         send_file();
      end
      calm = 0;

      wait_drained();
      repeat (20) @(negedge clock);
      $display("%0d files, %0d bytes; results: %0d pixel, %0d done, %0d magic, %0d token,",
               files_sent, bytes_sent, decode.kind_count[KIND_PIXEL],
               decode.kind_count[KIND_DONE], decode.kind_count[KIND_MAGIC],
               decode.kind_count[KIND_TOKEN]);
      $display("%0d header, %0d truncated; %0d field mismatches",
               decode.kind_count[KIND_DIMS], decode.kind_count[KIND_TRUNC],
               decode.mismatches);
      if (decode.mismatches == 0 && decode.outstanding() == 0) begin
         $display("pnm_header_parse_bgr_unpack_unit: match");
      end else begin
         $display("pnm_header_parse_bgr_unpack_unit: mismatch");
      end
      $finish;
   end
endmodule
